FILE: src/gsa_pkg.sv
`default_nettype none

package gsa_pkg;

  // Pool size; a power of two, so mapping an id to its slot is a mask.
  localparam int unsigned POOL_SLOTS = 1024;
  localparam int unsigned SLOT_W     = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W      = SLOT_W + 1;
  localparam int unsigned ID_W       = 31;
  localparam int unsigned MODE_W     = 2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ID_W-1:0]   id_t;

  localparam cnt_t POOL_CNT = cnt_t'(POOL_SLOTS);

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_LOOKUP  = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_ZERO_ID  = 2'd2,
    STAT_MISMATCH = 2'd3
  } status_e;

  // Free queue control from the sequencer.
  typedef struct packed {
    logic  pop;
    logic  push;
    slot_t push_slot;
    logic  init_we;
    slot_t init_addr;
  } fq_req_t;

  typedef struct packed {
    slot_t head_slot;
    cnt_t  count;
    logic  full;
  } fq_rsp_t;

endpackage

`default_nettype wire

FILE: src/gsa_ram.sv
`default_nettype none

module gsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/gsa_free_queue.sv
`default_nettype none

module gsa_free_queue
  import gsa_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire fq_req_t req_i,
  output      fq_rsp_t rsp_o
);

  slot_t head_q, head_d;
  slot_t tail_q, tail_d;
  cnt_t  count_q, count_d;
  logic  full;
  logic  do_push;
  logic  we;
  slot_t waddr;
  slot_t wdata;

  assign full    = (count_q == POOL_CNT);
  assign do_push = req_i.push && !full;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.pop) begin
      head_d  = head_q + slot_t'(1);
      count_d = count_q - cnt_t'(1);
    end
    if (do_push) begin
      tail_d  = tail_q + slot_t'(1);
      count_d = count_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= POOL_CNT;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // Clearing pass loads entry i with slot i.
  assign we    = req_i.init_we || do_push;
  assign waddr = req_i.init_we ? req_i.init_addr : tail_q;
  assign wdata = req_i.init_we ? req_i.init_addr : req_i.push_slot;

  gsa_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(POOL_SLOTS)
  ) u_fq_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(head_q),
    .rdata_o(rsp_o.head_slot)
  );

  assign rsp_o.count = count_q;
  assign rsp_o.full  = full;

endmodule

`default_nettype wire

FILE: src/generational_slot_allocator.sv
`default_nettype none

// Generational slot allocator. A pool of POOL_SLOTS slots is handed out through
// a FIFO free queue; each slot carries a 31-bit handle id (slot i starts with id
// i+1). Issue a transaction by raising start_i while busy_o is low. Allocate
// returns the oldest free slot and its id; lookup maps id to slot
// ((id mod POOL_SLOTS) - 1, wrapping) and checks the stored id; release checks
// the same way, queues the slot and bumps its id by POOL_SLOTS (restarting at
// slot+1 past 2^31-1). Every transaction gives exactly one result, shown for a
// single cycle with done_o high; the receiver cannot stall it, so capture it
// then. free_count_o is the free count after that transaction. Lookup and release
// make one registered read of the id table, then check and write back; allocate
// reads the free queue, then reads the id table at that slot; pool-empty, zero-id
// and unused-mode requests are answered from the idle state with no work state.
// After reset, busy_o stays high while a clearing pass loads both memories with
// their starting contents.
module generational_slot_allocator
  import gsa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output      logic              busy_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [ID_W-1:0]   handle_id_i,
  output      logic              done_o,
  output      logic [1:0]        status_o,
  output      logic [SLOT_W-1:0] slot_index_o,
  output      logic [ID_W-1:0]   slot_id_o,
  output      logic [CNT_W-1:0]  free_count_o
);

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_FQ_RD = 4'b0100,
    S_ID_RD = 4'b1000
  } state_e;

  state_e state_q, state_d;
  slot_t  init_q, init_d;

  // Transaction held while it works through the memories.
  logic [MODE_W-1:0] mode_q, mode_d;
  id_t               id_q, id_d;
  slot_t             slot_q, slot_d;

  // Result registers.
  logic    done_q, done_d;
  status_e status_q, status_d;
  slot_t   rslot_q, rslot_d;
  id_t     rid_q, rid_d;

  fq_req_t fq_req;
  fq_rsp_t fq_rsp;

  logic  accept;
  slot_t map_slot;
  id_t   ids_rdata;
  logic  ids_we;
  slot_t ids_waddr;
  id_t   ids_wdata;
  slot_t ids_raddr;
  logic [ID_W:0] bumped;
  id_t   new_id;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // Slot for an id: low bits minus one; remainder zero wraps to the last slot.
  assign map_slot = handle_id_i[SLOT_W-1:0] - slot_t'(1);

  // Release bump; on overflow past the 31-bit range, restart at slot+1.
  assign bumped = {1'b0, id_q} + (ID_W+1)'(POOL_SLOTS);
  assign new_id = bumped[ID_W] ? (id_t'(slot_q) + id_t'(1)) : bumped[ID_W-1:0];

  always_comb begin
    state_d  = state_q;
    init_d   = init_q;
    mode_d   = mode_q;
    id_d     = id_q;
    slot_d   = slot_q;
    done_d   = 1'b0;
    status_d = status_q;
    rslot_d  = rslot_q;
    rid_d    = rid_q;
    fq_req   = '0;
    ids_we    = 1'b0;
    ids_waddr = slot_q;
    ids_wdata = new_id;
    ids_raddr = map_slot;

    case (state_q)
      S_INIT: begin
        // Clearing pass: slot i gets id i+1 and queue entry i gets slot i.
        ids_we           = 1'b1;
        ids_waddr        = init_q;
        ids_wdata        = id_t'(init_q) + id_t'(1);
        fq_req.init_we   = 1'b1;
        fq_req.init_addr = init_q;
        init_d           = init_q + slot_t'(1);
        if (init_q == slot_t'(POOL_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d = mode_i;
          id_d   = handle_id_i;
          slot_d = map_slot;
          if (mode_i == MODE_ALLOC) begin
            if (fq_rsp.count == '0) begin
              done_d   = 1'b1;
              status_d = STAT_EMPTY;
              rslot_d  = '0;
              rid_d    = '0;
            end else begin
              // Head entry is already being read.
              state_d = S_FQ_RD;
            end
          end else if (mode_i == MODE_LOOKUP || mode_i == MODE_RELEASE) begin
            if (handle_id_i == '0) begin
              done_d   = 1'b1;
              status_d = STAT_ZERO_ID;
              rslot_d  = '0;
              rid_d    = '0;
            end else begin
              state_d = S_ID_RD;
            end
          end else begin
            // Unused mode: no operation.
            done_d   = 1'b1;
            status_d = STAT_OK;
            rslot_d  = '0;
            rid_d    = '0;
          end
        end
      end
      S_FQ_RD: begin
        // Pop the head slot and read its id.
        fq_req.pop = 1'b1;
        slot_d     = fq_rsp.head_slot;
        ids_raddr  = fq_rsp.head_slot;
        state_d    = S_ID_RD;
      end
      S_ID_RD: begin
        done_d  = 1'b1;
        rslot_d = slot_q;
        rid_d   = ids_rdata;
        state_d = S_IDLE;
        if (mode_q == MODE_ALLOC) begin
          status_d = STAT_OK;
        end else if (ids_rdata != id_q) begin
          status_d = STAT_MISMATCH;
        end else begin
          status_d = STAT_OK;
          if (mode_q == MODE_RELEASE) begin
            // Write back the bumped id and queue the slot; a full queue drops it.
            ids_we           = 1'b1;
            fq_req.push      = 1'b1;
            fq_req.push_slot = slot_q;
            rid_d            = new_id;
          end
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    id_q     <= id_d;
    slot_q   <= slot_d;
    status_q <= status_d;
    rslot_q  <= rslot_d;
    rid_q    <= rid_d;
  end

  gsa_ram #(
    .WIDTH(ID_W),
    .DEPTH(POOL_SLOTS)
  ) u_ids_ram (
    .clk_i  (clk_i),
    .we_i   (ids_we),
    .waddr_i(ids_waddr),
    .wdata_i(ids_wdata),
    .raddr_i(ids_raddr),
    .rdata_o(ids_rdata)
  );

  gsa_free_queue u_free_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (fq_req),
    .rsp_o (fq_rsp)
  );

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_index_o = rslot_q;
  assign slot_id_o    = rid_q;
  // Queue count only moves in work states, so it holds through the result cycle.
  assign free_count_o = fq_rsp.count;

  // An accepted transaction is either still working or reporting next cycle.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || done_o))
    else $error("accepted transaction neither busy nor done");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_count_o <= POOL_CNT)
    else $error("free count beyond pool size");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_EMPTY) |-> (free_count_o == '0))
    else $error("pool empty reported with free slots");

  a_zero_id_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_ZERO_ID) |-> (slot_index_o == '0 && slot_id_o == '0))
    else $error("zero id result carries a slot");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_req.pop |-> (fq_rsp.count != '0))
    else $error("pop from empty free queue");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gsa_pkg::*;

  // The block decodes the fourth mode value as a no-op; the package has no name for it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Random transactions, the pool-exhausting burst included; the burst alone needs about
  // one allocate per free slot, so it closes the run once it has been queued.
  localparam int unsigned RANDOM_ITEMS   = 880;
  localparam int unsigned PHASE_ITEMS    = 120;
  localparam int unsigned REPORT_LIMIT   = 10;
  // Longest quiet stretch of a correct run: the clearing pass after reset plus a run
  // of sender gaps. Allow several times that.
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned TAIL_CYCLES    = 8;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    id_t               id;
  } request_t;

  typedef struct packed {
    status_e status;
    slot_t   slot;
    id_t     id;
    cnt_t    count;
  } alloc_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic [MODE_W-1:0] mode_i      = '0;
  id_t               handle_id_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [1:0]        status_o;
  logic [SLOT_W-1:0] slot_index_o;
  logic [ID_W-1:0]   slot_id_o;
  logic [CNT_W-1:0]  free_count_o;

  generational_slot_allocator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .handle_id_i  (handle_id_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .slot_id_o    (slot_id_o),
    .free_count_o (free_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the allocator: id table, free ring and its pointers.
  id_t   pool_ids  [POOL_SLOTS];
  slot_t free_ring [POOL_SLOTS];
  slot_t ring_head;
  slot_t ring_tail;
  cnt_t  ring_count;

  request_t      request_queue[$];     // transactions waiting for the driver
  alloc_result_t expected_results[$];  // predicted results, oldest first
  slot_t         lent_slots[$];        // slots handed out and not yet given back

  logic        took_item    = 1'b0;    // a transaction was accepted at the last rising edge
  int unsigned gap_pct      = 16;      // chance in percent that the sender idles instead of offering
  int unsigned fault_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_accepted   = 0;
  int unsigned n_alloc      = 0;
  int unsigned n_lookup     = 0;
  int unsigned n_release    = 0;
  int unsigned n_unused     = 0;
  int unsigned n_empty      = 0;
  int unsigned n_zero_id    = 0;
  int unsigned n_bad_id     = 0;

  function automatic slot_t ring_next(slot_t p);
    return (p == slot_t'(POOL_SLOTS - 1)) ? '0 : p + slot_t'(1);
  endfunction

  // Apply one transaction to the shadow state and return the result it must produce.
  function automatic alloc_result_t allocator_step(logic [MODE_W-1:0] mode, id_t id);
    alloc_result_t res;
    slot_t         s;
    int unsigned   rem;
    logic [ID_W:0] bumped;
    res.status = STAT_OK;
    res.slot   = '0;
    res.id     = '0;
    if (mode == MODE_ALLOC) begin
      if (ring_count == '0) begin
        res.status = STAT_EMPTY;
      end else begin
        s          = free_ring[ring_head];
        ring_head  = ring_next(ring_head);
        ring_count = ring_count - cnt_t'(1);
        res.slot   = s;
        res.id     = pool_ids[s];
      end
    end else if (mode == MODE_UNUSED) begin
      // no-op: only the free count is reported
    end else if (id == '0) begin
      res.status = STAT_ZERO_ID;
    end else begin
      // Id k maps to slot (k mod N) - 1; a remainder of zero lands on the last slot.
      rem = id % POOL_SLOTS;
      s   = (rem == 0) ? slot_t'(POOL_SLOTS - 1) : slot_t'(rem - 1);
      if (pool_ids[s] != id) begin
        res.status = STAT_MISMATCH;
      end else if (mode == MODE_RELEASE) begin
        // A full ring drops the push, but the id still advances.
        if (ring_count < POOL_CNT) begin
          free_ring[ring_tail] = s;
          ring_tail            = ring_next(ring_tail);
          ring_count           = ring_count + cnt_t'(1);
        end
        bumped = {1'b0, id} + (ID_W + 1)'(POOL_SLOTS);
        // Past the 31-bit range the generation restarts at slot + 1.
        pool_ids[s] = bumped[ID_W] ? id_t'(s) + id_t'(1) : bumped[ID_W-1:0];
      end
      res.slot = s;
      res.id   = pool_ids[s];
    end
    res.count = ring_count;
    return res;
  endfunction

  task automatic queue_request(logic [MODE_W-1:0] mode, id_t id);
    request_t req;
    req.mode = mode;
    req.id   = id;
    request_queue.push_back(req);
  endtask

  // Hold until nothing is queued, nothing is offered and every result has come back.
  task automatic wait_quiet();
    while (request_queue.size() != 0 || start_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: change inputs on the falling edge. Keep an offered transaction steady
  // until it is taken, then either offer the next one or let start_i fall.
  always @(negedge clk_i) begin : driver
    request_t req;
    if (!start_i || took_item) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        req = request_queue.pop_front();
        start_i     <= 1'b1;
        mode_i      <= req.mode;
        handle_id_i <= req.id;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: sample on the rising edge. Check a result against the oldest
  // prediction first, then predict for a transaction taken at this same edge.
  always @(posedge clk_i) begin : monitor
    alloc_result_t want;
    took_item <= rst_ni && start_i === 1'b1 && busy_o === 1'b0;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("unexpected result: status %0d slot %0d id %0d free %0d",
                     status_o, slot_index_o, slot_id_o, free_count_o);
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status || slot_index_o !== want.slot ||
              slot_id_o !== want.id || free_count_o !== want.count) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
              $display({"mismatch: expected status %0d slot %0d id %0d free %0d, ",
                        "got status %0d slot %0d id %0d free %0d"},
                       want.status, want.slot, want.id, want.count,
                       status_o, slot_index_o, slot_id_o, free_count_o);
          end
        end
      end
      if (start_i === 1'b1 && busy_o === 1'b0) begin
        want = allocator_step(mode_i, handle_id_i);
        expected_results.push_back(want);
        n_accepted++;
        if (mode_i == MODE_ALLOC) n_alloc++;
        else if (mode_i == MODE_LOOKUP) n_lookup++;
        else if (mode_i == MODE_RELEASE) n_release++;
        else n_unused++;
        if (want.status == STAT_EMPTY) n_empty++;
        else if (want.status == STAT_ZERO_ID) n_zero_id++;
        else if (want.status == STAT_MISMATCH) n_bad_id++;
        // Remember granted slots so the stimulus can hand them back with live ids.
        if (mode_i == MODE_ALLOC && want.status == STAT_OK)
          lent_slots.push_back(want.slot);
      end
    end
  end

  // Watchdog: end the run when nothing moves in either direction for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int          r;
    int unsigned idx;
    int unsigned burst;
    slot_t       s;

    // Bring the shadow to its reset contents: every slot free, slot i owns id i+1.
    for (int i = 0; i < POOL_SLOTS; i++) begin
      pool_ids[i]  = id_t'(i + 1);
      free_ring[i] = slot_t'(i);
    end
    ring_head  = '0;
    ring_tail  = '0;
    ring_count = POOL_CNT;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero ids, first and last slot, ids that alias onto the last slot,
    // the unused mode, release into a full ring, and a double release.
    queue_request(MODE_LOOKUP, '0);
    queue_request(MODE_RELEASE, '0);
    queue_request(MODE_LOOKUP, id_t'(1));
    queue_request(MODE_LOOKUP, id_t'(POOL_SLOTS));
    queue_request(MODE_LOOKUP, id_t'(2 * POOL_SLOTS));
    queue_request(MODE_LOOKUP, '1);
    queue_request(MODE_RELEASE, id_t'(POOL_SLOTS + 1));
    queue_request(MODE_UNUSED, '1);
    queue_request(MODE_UNUSED, '0);
    queue_request(MODE_RELEASE, id_t'(5));       // ring full: push dropped, id bumped
    queue_request(MODE_RELEASE, id_t'(5));       // now stale
    queue_request(MODE_ALLOC, '1);
    queue_request(MODE_ALLOC, '0);
    queue_request(MODE_LOOKUP, id_t'(1));
    queue_request(MODE_RELEASE, id_t'(1));
    queue_request(MODE_RELEASE, id_t'(POOL_SLOTS + 1));      // already free: queued twice
    queue_request(MODE_LOOKUP, id_t'(2 * POOL_SLOTS + 1));
    queue_request(MODE_RELEASE, id_t'(2));                   // ring full again
    queue_request(MODE_ALLOC, id_t'($urandom));
    queue_request(MODE_RELEASE, '1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Switch the sender's gap rate per phase; pause for a full drain at each switch.
      if (n == PHASE_ITEMS) begin
        wait_quiet();
        gap_pct = 76;
      end else if (n == 2 * PHASE_ITEMS) begin
        wait_quiet();
        gap_pct = 0;
        // Exhaust the pool and knock on it a few times while it is empty.
        burst = ring_count + 3;
        for (int k = 0; k < burst; k++)
          queue_request(MODE_ALLOC, id_t'($urandom));
        n = n + int'(burst);
      end
      while (request_queue.size() != 0) @(posedge clk_i);

      r = $urandom_range(99);
      s = slot_t'($urandom_range(POOL_SLOTS - 1));
      if (r < 45 || (r < 70 && lent_slots.size() == 0)) begin
        queue_request(MODE_ALLOC, id_t'($urandom));
      end else if (r < 70) begin
        // Hand back a granted slot with its live id.
        idx = $urandom_range(lent_slots.size() - 1);
        s   = lent_slots[idx];
        lent_slots.delete(idx);
        queue_request(MODE_RELEASE, pool_ids[s]);
      end else if (r < 82) begin
        queue_request(MODE_LOOKUP, pool_ids[s]);
      end else if (r < 88) begin
        // Live id of any slot, free or not: exercises double queuing and a full ring.
        queue_request(MODE_RELEASE, pool_ids[s]);
      end else if (r < 92) begin
        // Near miss: one bit flipped in a live id.
        queue_request(r[0] ? MODE_LOOKUP : MODE_RELEASE,
                      pool_ids[s] ^ (id_t'(1) << $urandom_range(ID_W - 1)));
      end else if (r < 96) begin
        queue_request(r[0] ? MODE_LOOKUP : MODE_RELEASE, id_t'($urandom));
      end else if (r < 98) begin
        queue_request(r[0] ? MODE_LOOKUP : MODE_RELEASE, '0);
      end else begin
        queue_request(MODE_UNUSED, id_t'($urandom));
      end
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d transactions: %0d allocate, %0d lookup, %0d release, %0d unused mode",
             n_accepted, n_alloc, n_lookup, n_release, n_unused);
    $display("pool empty %0d times, zero id %0d times, stale or foreign id %0d times",
             n_empty, n_zero_id, n_bad_id);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failing results", fault_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/gsa_pkg.sv
src/gsa_ram.sv
src/gsa_free_queue.sv
src/generational_slot_allocator.sv
verif/testbench.sv
